[rtl/smx_pkg.sv]
// smx_pkg: shared constants, opcodes, trap codes and the execute-result struct
// for the stack machine execute block. No dependencies.
package smx_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 1024;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int OP_W    = 3;
  localparam int VAL_W   = 64;
  localparam int TRAP_W  = 2;
  localparam int DEPTH_W = 11;

  // Stream bus widths, padded to whole bytes
  localparam int S_DATA_BITS = OP_W + VAL_W;
  localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = TRAP_W + VAL_W + DEPTH_W;
  localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_EQ   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP  = 3'd4;

  // Trap codes
  localparam logic [TRAP_W-1:0] TRAP_NONE    = 2'd0;
  localparam logic [TRAP_W-1:0] TRAP_OVER    = 2'd1;
  localparam logic [TRAP_W-1:0] TRAP_UNDER   = 2'd2;
  localparam logic [TRAP_W-1:0] TRAP_ILLEGAL = 2'd3;

  // Outcome of one instruction, from the execute logic to the top level
  typedef struct packed {
    logic [TRAP_W-1:0] trap;
    logic [VAL_W-1:0]  popped;
    logic [CNT_W-1:0]  count_next;
    logic [VAL_W-1:0]  top_next;
    logic              wr_en;     // spill old top into the stack memory
    logic [PTR_W-1:0]  wr_addr;
  } exec_res_t;

endpackage

[rtl/smx_stack_ram.sv]
// smx_stack_ram: generic single-port-write, single-port-read synchronous RAM
// with registered read data. No dependencies.
module smx_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

[rtl/smx_exec.sv]
// smx_exec: instruction decode, trap checks and 64-bit add/sub/compare for one
// stack instruction. Depends on smx_pkg.
module smx_exec (
  input  logic [smx_pkg::OP_W-1:0]  op,
  input  logic [smx_pkg::VAL_W-1:0] push_val,
  input  logic [smx_pkg::CNT_W-1:0] count,
  input  logic [smx_pkg::VAL_W-1:0] top,      // entry count-1, held in a register
  input  logic [smx_pkg::VAL_W-1:0] second,   // entry count-2, from the RAM
  output smx_pkg::exec_res_t        res
);
  import smx_pkg::*;

  logic             full;
  logic             lt2;
  logic             empty;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_inc;

  assign full    = (count >= CNT_W'(STACK_DEPTH));
  assign lt2     = (count < CNT_W'(2));
  assign empty   = (count == '0);
  assign cnt_m1  = count - CNT_W'(1);
  assign cnt_inc = count + CNT_W'(1);

  always_comb begin
    res            = '0;
    res.count_next = count;
    res.top_next   = top;
    res.wr_addr    = cnt_m1[PTR_W-1:0];
    unique case (op) inside
      OP_PUSH: begin
        if (full) begin
          res.trap = TRAP_OVER;
        end else begin
          res.wr_en      = !empty;
          res.top_next   = push_val;
          res.count_next = cnt_inc;
        end
      end
      OP_ADD, OP_SUB: begin
        if (lt2) begin
          res.trap = TRAP_UNDER;
        end else begin
          res.top_next   = (op == OP_ADD) ? second + top : second - top;
          res.count_next = cnt_m1;
        end
      end
      OP_EQ: begin
        if (lt2) begin
          res.trap = TRAP_UNDER;
        end else if (full) begin
          res.trap = TRAP_OVER;
        end else begin
          res.wr_en      = 1'b1;
          res.top_next   = VAL_W'(second == top);
          res.count_next = cnt_inc;
        end
      end
      OP_POP: begin
        if (empty) begin
          res.trap = TRAP_UNDER;
        end else begin
          res.popped     = top;
          res.top_next   = second;   // meaningless once the stack is empty
          res.count_next = cnt_m1;
        end
      end
      default: begin
        res.trap = TRAP_ILLEGAL;
      end
    endcase
  end

endmodule

[rtl/stack_machine_execute.sv]
// stack_machine_execute: top level of the stack machine execute block.
// Depends on smx_pkg, smx_stack_ram and smx_exec.
//
//  channel | dir | handshake          | payload (low bit first)
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | operation[2:0], push_value[66:3], pad
//  m_*     | out | m_tvalid/m_tready  | trap_code[1:0], popped_value[65:2],
//          |     |                    | depth_after[76:66], pad
//
// Each instruction: the transfer cycle issues the RAM read of the second entry
// (count-2), then ST_EXEC executes and writes back once the output is free. The top
// of stack lives in a register, so the RAM sees one read and at most one write
// per instruction; a new instruction is taken only after the last one executes.
// Reset (rst, synchronous) empties the stack; RAM contents are not cleared.
// The result goes to an output register; a new transfer is taken while it
// waits. Execution holds if the output register is still full.
module stack_machine_execute (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [smx_pkg::S_TDATA_W-1:0] s_tdata,  // operation, push_value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [smx_pkg::M_TDATA_W-1:0] m_tdata   // trap_code, popped_value, depth_after
);
  import smx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Instruction registers, loaded on an input transfer
  logic [OP_W-1:0]  op;
  logic [VAL_W-1:0] push_val;

  // Stack state: count of valid entries and cached top entry
  logic [CNT_W-1:0] count;
  logic [VAL_W-1:0] top;

  // Output register
  logic              out_valid;
  logic [TRAP_W-1:0] out_trap;
  logic [VAL_W-1:0]  out_popped;
  logic [DEPTH_W-1:0] out_depth;

  logic             s_xfer;
  logic             out_free;
  logic             exec_go;
  logic [CNT_W-1:0] cnt_m2;
  logic [VAL_W-1:0] second;
  exec_res_t        res;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign exec_go  = (state == ST_EXEC) && out_free;
  assign cnt_m2   = count - CNT_W'(2);

  // Entries below count-1 live in the RAM
  smx_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VAL_W),
    .AW    (PTR_W)
  ) u_ram (
    .clk (clk),
    .we  (exec_go && res.wr_en),
    .wa  (res.wr_addr),
    .wd  (top),
    .re  (s_xfer),
    .ra  (cnt_m2[PTR_W-1:0]),
    .rd  (second)
  );

  smx_exec u_exec (
    .op       (op),
    .push_val (push_val),
    .count    (count),
    .top      (top),
    .second   (second),
    .res      (res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        count     <= res.count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      op       <= s_tdata[OP_W-1:0];
      push_val <= s_tdata[OP_W +: VAL_W];
    end
    if (exec_go) begin
      top        <= res.top_next;
      out_trap   <= res.trap;
      out_popped <= res.popped;
      out_depth  <= DEPTH_W'(res.count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_depth, out_popped, out_trap});

endmodule
